// ----- hw/rtl/ubxfr_pkg.sv -----
// shared types and constants of the ubx frame receiver
// no dependencies
package ubxfr_pkg;

  localparam int unsigned MaxFrameBytesDef = 256;
  localparam int unsigned QueueDepthDef    = 4;
  localparam int unsigned HdrLen           = 6;
  localparam int unsigned Overhead         = 8;

  // frame phase codes
  localparam logic [2:0] PhHunt  = 3'd0;
  localparam logic [2:0] PhSync2 = 3'd1;
  localparam logic [2:0] PhClass = 3'd2;
  localparam logic [2:0] PhId    = 3'd3;
  localparam logic [2:0] PhLenLo = 3'd4;
  localparam logic [2:0] PhLenHi = 3'd5;
  localparam logic [2:0] PhBody  = 3'd6;

  // register indexes
  localparam logic [1:0] RegSyncFirst = 2'd0;
  localparam logic [1:0] RegSyncSecond = 2'd1;
  localparam logic [1:0] RegMaxTotal  = 2'd2;

  localparam logic [7:0] SyncFirstRst  = 8'hB5;
  localparam logic [7:0] SyncSecondRst = 8'h62;
  localparam logic [8:0] MaxTotalRst   = 9'd256;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [8:0] max_total_length;
  } cfg_t;

  // one queue entry: either a whole header release or one body byte
  typedef struct packed {
    logic                    is_hdr;
    logic [HdrLen-1:0][7:0]  hdr;
    logic [7:0]              data;
    logic [7:0]              index;
    logic                    last;
    logic                    ok;
  } entry_t;

endpackage

// ----- hw/rtl/ubxfr_queue.sv -----
// small flop queue between the front and back parts
// depends on ubxfr_pkg
module ubxfr_queue #(
  parameter int unsigned Depth = ubxfr_pkg::QueueDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ubxfr_pkg::entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output ubxfr_pkg::entry_t head_o,
  output logic              empty_o
);
  import ubxfr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t           mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ----- hw/rtl/ubxfr_front.sv -----
// front part: sync hunt, header capture, length check, fletcher sums
// depends on ubxfr_pkg
module ubxfr_front #(
  parameter int unsigned MaxFrameBytes = ubxfr_pkg::MaxFrameBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  input  ubxfr_pkg::cfg_t   cfg_i,
  output logic              push_o,
  output ubxfr_pkg::entry_t entry_o,
  input  logic              full_i
);
  import ubxfr_pkg::*;

  localparam int unsigned RemW = $clog2(MaxFrameBytes);

  logic [2:0]         phase_q, phase_d;
  logic [7:0]         hdr_q [HdrLen];
  logic [RemW-1:0]    rem_q, rem_d;
  logic [7:0]         pos_q, pos_d;
  logic [7:0]         sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [7:0]         chk_a_q, chk_a_d;
  logic [7:0]         add_a, add_b;
  logic               acc;
  logic [16:0]        total, lim_cfg, lim;
  logic [15:0]        payload;

  assign in_stall_o = full_i;
  assign acc        = in_valid_i && !full_i;

  assign add_a   = sum_a_q + rx_byte_i;
  assign add_b   = sum_b_q + add_a;
  assign payload = {rx_byte_i, hdr_q[4]};
  assign total   = {1'b0, payload} + 17'(Overhead);
  assign lim_cfg = {8'd0, cfg_i.max_total_length};
  assign lim     = (lim_cfg > 17'(MaxFrameBytes)) ? 17'(MaxFrameBytes) : lim_cfg;

  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    chk_a_d = chk_a_q;
    push_o  = 1'b0;
    entry_o = '0;
    entry_o.data  = rx_byte_i;
    entry_o.index = pos_q;
    for (int k = 0; k < HdrLen - 1; k++) begin
      entry_o.hdr[k] = hdr_q[k];
    end
    entry_o.hdr[HdrLen-1] = rx_byte_i;
    if (acc) begin
      case (phase_q)
        PhSync2: begin
          phase_d = (rx_byte_i == cfg_i.sync_second) ? PhClass : PhHunt;
        end
        PhClass: begin
          sum_a_d = rx_byte_i;
          sum_b_d = rx_byte_i;
          phase_d = PhId;
        end
        PhId: begin
          sum_a_d = add_a;
          sum_b_d = add_b;
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          sum_a_d = add_a;
          sum_b_d = add_b;
          phase_d = PhLenHi;
        end
        PhLenHi: begin
          if (total > lim) begin
            phase_d = PhHunt;
          end else begin
            sum_a_d        = add_a;
            sum_b_d        = add_b;
            push_o         = 1'b1;
            entry_o.is_hdr = 1'b1;
            rem_d          = RemW'(payload + 16'd2);
            pos_d          = 8'(HdrLen);
            phase_d        = PhBody;
          end
        end
        PhBody: begin
          push_o = 1'b1;
          if (rem_q > RemW'(2)) begin
            sum_a_d = add_a;
            sum_b_d = add_b;
            rem_d   = rem_q - RemW'(1);
            pos_d   = pos_q + 8'd1;
          end else if (rem_q == RemW'(2)) begin
            chk_a_d = rx_byte_i;
            rem_d   = rem_q - RemW'(1);
            pos_d   = pos_q + 8'd1;
          end else begin
            entry_o.last = 1'b1;
            entry_o.ok   = (chk_a_q == sum_a_q) && (rx_byte_i == sum_b_q);
            rem_d        = '0;
            pos_d        = '0;
            phase_d      = PhHunt;
          end
        end
        default: begin
          phase_d = (rx_byte_i == cfg_i.sync_first) ? PhSync2 : PhHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      rem_q   <= '0;
      pos_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      chk_a_q <= '0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      chk_a_q <= chk_a_d;
    end
  end

  // header bytes, captured by phase
  always_ff @(posedge clk_i) begin
    if (acc) begin
      case (phase_q)
        PhSync2: hdr_q[1] <= rx_byte_i;
        PhClass: hdr_q[2] <= rx_byte_i;
        PhId:    hdr_q[3] <= rx_byte_i;
        PhLenLo: hdr_q[4] <= rx_byte_i;
        PhLenHi: hdr_q[5] <= rx_byte_i;
        PhBody:  ;
        default: hdr_q[0] <= rx_byte_i;
      endcase
    end
  end

endmodule

// ----- hw/rtl/ubxfr_back.sv -----
// back part: unrolls header entries into six items, drives the output register
// depends on ubxfr_pkg
module ubxfr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ubxfr_pkg::entry_t head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        frame_byte_o,
  output logic [7:0]        byte_index_o,
  output logic              is_last_o,
  output logic              checksum_ok_o
);
  import ubxfr_pkg::*;

  localparam int unsigned HdrCntW = $clog2(HdrLen);

  logic               valid_q, valid_d;
  logic [7:0]         byte_q, byte_d, idx_q, idx_d;
  logic               last_q, last_d, ok_q, ok_d;
  logic [HdrCntW-1:0] hcnt_q, hcnt_d;
  logic               load;

  assign load = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    idx_d   = idx_q;
    last_d  = last_q;
    ok_d    = ok_q;
    hcnt_d  = hcnt_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        if (head_i.is_hdr) begin
          byte_d = head_i.hdr[hcnt_q];
          idx_d  = 8'(hcnt_q);
          last_d = 1'b0;
          ok_d   = 1'b0;
          if (hcnt_q == HdrCntW'(HdrLen - 1)) begin
            hcnt_d = '0;
            pop_o  = 1'b1;
          end else begin
            hcnt_d = hcnt_q + HdrCntW'(1);
          end
        end else begin
          byte_d = head_i.data;
          idx_d  = head_i.index;
          last_d = head_i.last;
          ok_d   = head_i.ok;
          pop_o  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hcnt_q  <= '0;
    end else begin
      valid_q <= valid_d;
      hcnt_q  <= hcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    idx_q  <= idx_d;
    last_q <= last_d;
    ok_q   <= ok_d;
  end

  assign out_valid_o   = valid_q;
  assign frame_byte_o  = byte_q;
  assign byte_index_o  = idx_q;
  assign is_last_o     = last_q;
  assign checksum_ok_o = ok_q;

endmodule

// ----- hw/rtl/ubx_frame_receiver_unit.sv -----
// top level of the ubx frame receiver: apb registers, front, queue, back
// depends on ubxfr_pkg, ubxfr_front, ubxfr_queue, ubxfr_back
//
// Takes one received serial byte per item and hunts for the two sync bytes
// (registers sync_first and sync_second, reset 0xB5 and 0x62). A byte after
// sync 1 that is not sync 2 drops both. Class, id and a little-endian 16-bit
// payload length follow; a frame whose payload plus 8 exceeds the smaller of
// max_total_length and MaxFrameBytes is dropped silently. An accepted frame
// comes out as one item per byte: the six header bytes all at once when the
// second length byte arrives, then every payload and checksum byte as it
// arrives, with byte_index counting from sync 1 (modulo 256) and is_last on
// the second checksum byte, where checksum_ok carries the Fletcher-8 result
// over class..payload. An input byte is taken whenever the QueueDepth-entry
// queue between the front (phase machine and sums) and the back (output
// register) has room, so bytes may arrive back to back. While the output is
// not stalled, the back gives one item per cycle: a body byte passes through
// the queue and then the output register, and a header release occupies the
// output for six items. With body bytes arriving back to back and the output
// never stalled, the queue fills during a header release and the input
// stalls when QueueDepth is below seven; after that body bytes flow at one
// per cycle. Registers sit at byte addresses 0, 4 and 8, should be written
// only while the block is idle (the block itself does not enforce this) and
// need no clearing pass after reset.
module ubx_frame_receiver_unit #(
  parameter int unsigned MaxFrameBytes = ubxfr_pkg::MaxFrameBytesDef,
  parameter int unsigned QueueDepth    = ubxfr_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // result item channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic [7:0]  byte_index_o,
  output logic        is_last_o,
  output logic        checksum_ok_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ubxfr_pkg::*;

  cfg_t       cfg_q;
  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       push, pop, full, empty;
  entry_t     entry, head;

  // register file: index from the word address, low address bits ignored
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first       <= SyncFirstRst;
      cfg_q.sync_second      <= SyncSecondRst;
      cfg_q.max_total_length <= MaxTotalRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegSyncFirst:  cfg_q.sync_first       <= pwdata[7:0];
        RegSyncSecond: cfg_q.sync_second      <= pwdata[7:0];
        RegMaxTotal:   cfg_q.max_total_length <= pwdata[8:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegSyncFirst:  prdata = {24'd0, cfg_q.sync_first};
      RegSyncSecond: prdata = {24'd0, cfg_q.sync_second};
      RegMaxTotal:   prdata = {23'd0, cfg_q.max_total_length};
      default:       prdata = '0;
    endcase
  end

  // front: phase machine, header capture, length check, running sums
  ubxfr_front #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg_q),
    .push_o    (push),
    .entry_o   (entry),
    .full_i    (full)
  );

  // decoupling queue, stalls the input only when full
  ubxfr_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(empty)
  );

  // back: one item per cycle into the output register while it is not stalled
  ubxfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .byte_index_o (byte_index_o),
    .is_last_o    (is_last_o),
    .checksum_ok_o(checksum_ok_o)
  );

endmodule

// ----- hw/rtl/ubxfr_checker.sv -----
// port-level checks of the ubx frame receiver, bound to the top level
// depends on ubx_frame_receiver_unit
module ubxfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] frame_byte_o,
  input logic [7:0] byte_index_o,
  input logic       is_last_o,
  input logic       checksum_ok_o,
  input logic       pready
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_byte_o) &&
      $stable(byte_index_o) && $stable(is_last_o) && $stable(checksum_ok_o))
    else $error("stalled result changed");

  // checksum flag only on the closing byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_last_o |-> !checksum_ok_o)
    else $error("checksum flag outside last byte");

  // a frame has at least eight bytes, so the closing byte sits at index seven or later
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_last_o |-> byte_index_o >= 8'd7)
    else $error("frame ended too early");

  // register port never waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind ubx_frame_receiver_unit ubxfr_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .frame_byte_o (frame_byte_o),
  .byte_index_o (byte_index_o),
  .is_last_o    (is_last_o),
  .checksum_ok_o(checksum_ok_o),
  .pready       (pready)
);
